// File: src/tcon_pkg.sv
package tcon_pkg;

    // Screen geometry and field widths.
    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CELL_W = 16;

    // Character codes the parser reacts to.
    localparam logic [7:0] CH_BS     = 8'd8;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_ESC    = 8'd27;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_TILDE  = 8'd126;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_NINE   = 8'd57;
    localparam logic [7:0] CH_LBRACK = 8'd91;
    localparam logic [7:0] CH_CMD_J  = 8'd74;
    localparam logic [7:0] CH_CMD_K  = 8'd75;
    localparam logic [7:0] CH_CMD_H  = 8'd72;

    // Attribute and blank cell after reset.
    localparam logic [7:0]        ATTR_RST  = 8'h07;
    localparam logic [CELL_W-1:0] BLANK_RST = {ATTR_RST, CH_SPACE};

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_SWEEP,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_TEXT,
        PH_ESC,
        PH_CSI
    } t_phase;

    // Requests from the controller to the screen memory.
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [CELL_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              sw_start;
        logic [ADDR_W-1:0] sw_base;
        logic [ADDR_W-1:0] sw_last;
        logic [CELL_W-1:0] sw_data;
    } t_scr_cmd;

    // Status returned by the screen memory.
    typedef struct packed {
        logic              sw_busy;
        logic [CELL_W-1:0] rd_data;
    } t_scr_stat;

endpackage

// File: src/tcon_screen.sv
module tcon_screen (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcon_pkg::t_scr_cmd i_cmd,
    output tcon_pkg::t_scr_stat o_stat
);
    import tcon_pkg::*;

    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rd_data;
    logic              r_sw_act;
    logic [ADDR_W-1:0] r_sw_addr;
    logic [ADDR_W-1:0] r_sw_last;
    logic [CELL_W-1:0] r_sw_data;

    // Single write port: the fill sweep has priority over single-cell writes.
    always_ff @(posedge i_clk) begin
        if (r_sw_act) begin
            r_mem[r_sw_addr] <= r_sw_data;
        end else if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.rd_addr];
        end
    end

    // Fill sweep: one cell a cycle over an address range. Reset blanks the
    // whole screen this way.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_act  <= 1'b1;
            r_sw_addr <= '0;
            r_sw_last <= ADDR_W'(CELLS - 1);
            r_sw_data <= BLANK_RST;
        end else if (i_cmd.sw_start) begin
            r_sw_act  <= 1'b1;
            r_sw_addr <= i_cmd.sw_base;
            r_sw_last <= i_cmd.sw_last;
            r_sw_data <= i_cmd.sw_data;
        end else if (r_sw_act) begin
            if (r_sw_addr == r_sw_last) begin
                r_sw_act <= 1'b0;
            end else begin
                r_sw_addr <= r_sw_addr + 1'b1;
            end
        end
    end

    assign o_stat.sw_busy = r_sw_act;
    assign o_stat.rd_data = r_rd_data;

    // The sweep never runs past the end of its range or of the memory.
    a_sweep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sw_act |-> (r_sw_addr <= r_sw_last) && (r_sw_last < ADDR_W'(CELLS)))
        else $error("sweep address out of range");

    // A single-cell write must not be requested while a sweep owns the port.
    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_sw_act && i_cmd.wr_en))
        else $error("cell write dropped during sweep");

endmodule

// File: src/text_console_with_escape_parser.sv
// Channel   Word fields (lowest bit first)                          Direction
// s_axis    tdata: data_byte[7:0] read_row[12:8] read_col[19:13]    in
//           tuser: action (0 feed byte, 1 read cell)
// m_axis    tdata: cell_code[7:0] cell_attr[15:8] cursor_row[20:16]  out
//                  cursor_col[27:21]
// cfg       i_cfg_we / i_cfg_data: text attribute                   in
//
// A feed word is accepted, executed and loaded into the output register; a
// read word also passes through a state that waits for the memory read.
// A line blank (scroll past the bottom row, ESC[2K) and a screen clear (ESC[2J)
// run a fill sweep over the row or the whole screen: the single memory write
// port fills one cell a cycle, and the word waits until the fill ends.
// Scrolling moves a top-row pointer.
// After reset a clearing pass blanks the screen; no word is
// accepted until it ends. A stalled output register holds one result while
// the next word is accepted and executed.
module text_console_with_escape_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // data_byte, read_row, read_col, zero pad
    input  logic        s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // cell_code, cell_attr, cursor_row,
                                       // cursor_col, zero pad
);
    import tcon_pkg::*;

    t_state            r_state, n_state;
    t_phase            r_phase, n_phase;
    logic [7:0]        r_attr;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_top, n_top;
    logic [7:0]        r_param, n_param;
    logic              r_seen, n_seen;

    logic              r_action;
    logic [7:0]        r_byte;
    logic [ROW_W-1:0]  r_rrow;
    logic [COL_W-1:0]  r_rcol;
    logic              r_rd_ok;
    logic [7:0]        r_code;
    logic [7:0]        r_cattr;
    logic              r_ovalid;
    logic [31:0]       r_odata;

    logic              dec_wr;
    logic [ADDR_W-1:0] dec_wr_addr;
    logic [CELL_W-1:0] dec_wr_data;
    logic              dec_rd;
    logic              dec_sw;
    logic [ADDR_W-1:0] dec_sw_base;
    logic [ADDR_W-1:0] dec_sw_last;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [CELL_W-1:0] blank;
    logic              rd_in_range;

    t_scr_cmd          scr_cmd;
    t_scr_stat         scr_stat;

    // Logical row to physical row of the circular screen.
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                  input logic [ROW_W-1:0] top);
        logic [ROW_W:0] sum;
        sum = {1'b0, row} + {1'b0, top};
        if (sum >= (ROW_W + 1)'(ROWS)) begin
            sum = sum - (ROW_W + 1)'(ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] row_base(input logic [ROW_W-1:0] prow);
        return ADDR_W'(prow) * ADDR_W'(COLS);
    endfunction

    tcon_screen u_screen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (scr_cmd),
        .o_stat  (scr_stat)
    );

    // Addresses and blank cell.
    assign blank       = {r_attr, CH_SPACE};
    assign cur_addr    = row_base(phys_row(r_row, r_top)) + ADDR_W'(r_col);
    assign rd_addr     = row_base(phys_row(r_rrow, r_top)) + ADDR_W'(r_rcol);
    assign rd_in_range = (r_rrow < ROW_W'(ROWS)) && (r_rcol < COL_W'(COLS));

    // Byte decode: parser phase, cursor movement and memory requests.
    always_comb begin
        logic          is_text;
        logic          do_nl;
        logic [11:0]   acc;
        is_text     = 1'b0;
        do_nl       = 1'b0;
        acc         = 12'({4'd0, r_param}) * 12'd10 + 12'(r_byte - CH_ZERO);
        n_phase     = r_phase;
        n_row       = r_row;
        n_col       = r_col;
        n_top       = r_top;
        n_param     = r_param;
        n_seen      = r_seen;
        dec_wr      = 1'b0;
        dec_wr_addr = cur_addr;
        dec_wr_data = blank;
        dec_rd      = 1'b0;
        dec_sw      = 1'b0;
        dec_sw_base = row_base(phys_row(r_row, r_top));
        dec_sw_last = row_base(phys_row(r_row, r_top)) + ADDR_W'(COLS - 1);
        if (r_action) begin
            dec_rd = rd_in_range;
        end else begin
            case (r_phase)
                PH_ESC: begin
                    n_phase = PH_TEXT;
                    if (r_byte == CH_LBRACK) begin
                        n_phase = PH_CSI;
                        n_param = '0;
                        n_seen  = 1'b0;
                    end else begin
                        is_text = 1'b1;
                    end
                end
                PH_CSI: begin
                    if (r_byte inside {[CH_ZERO:CH_NINE]}) begin
                        n_seen  = 1'b1;
                        n_param = (acc > 12'd255) ? 8'd255 : acc[7:0];
                    end else begin
                        n_phase = PH_TEXT;
                        if (r_byte == CH_CMD_J && r_seen && r_param == 8'd2) begin
                            dec_sw      = 1'b1;
                            dec_sw_base = '0;
                            dec_sw_last = ADDR_W'(CELLS - 1);
                            n_top       = '0;
                            n_row       = '0;
                            n_col       = '0;
                        end else if (r_byte == CH_CMD_K && r_seen
                                     && r_param == 8'd2) begin
                            dec_sw = 1'b1;
                            n_col  = '0;
                        end else if (r_byte == CH_CMD_H) begin
                            n_row = '0;
                            n_col = '0;
                        end
                    end
                end
                default: begin
                    is_text = 1'b1;
                end
            endcase
        end

        // Plain text handling.
        if (is_text) begin
            if (r_byte == CH_ESC) begin
                n_phase = PH_ESC;
            end else if (r_byte == CH_CR) begin
                n_col = '0;
            end else if (r_byte == CH_LF) begin
                do_nl = 1'b1;
            end else if (r_byte == CH_BS) begin
                if (r_col != '0) begin
                    n_col       = r_col - 1'b1;
                    dec_wr      = 1'b1;
                    dec_wr_addr = cur_addr - 1'b1;
                end
            end else if (r_byte >= CH_SPACE && r_byte <= CH_TILDE) begin
                dec_wr      = 1'b1;
                dec_wr_data = {r_attr, r_byte};
                if (r_col == COL_W'(COLS - 1)) begin
                    do_nl = 1'b1;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
        end

        // New line; at the bottom row the old top row becomes the new last row.
        if (do_nl) begin
            n_col = '0;
            if (r_row == ROW_W'(ROWS - 1)) begin
                n_top       = (r_top == ROW_W'(ROWS - 1)) ? '0 : r_top + 1'b1;
                dec_sw      = 1'b1;
                dec_sw_base = row_base(r_top);
                dec_sw_last = row_base(r_top) + ADDR_W'(COLS - 1);
            end else begin
                n_row = r_row + 1'b1;
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT:   if (!scr_stat.sw_busy) n_state = ST_IDLE;
            ST_IDLE:   if (s_axis_tvalid) n_state = ST_EXEC;
            ST_EXEC: begin
                if (r_action) begin
                    n_state = ST_RDWAIT;
                end else if (dec_sw) begin
                    n_state = ST_SWEEP;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_RDWAIT: n_state = ST_EMIT;
            ST_SWEEP:  if (!scr_stat.sw_busy) n_state = ST_EMIT;
            ST_EMIT:   if (!r_ovalid || m_axis_tready) n_state = ST_IDLE;
            default:   n_state = ST_INIT;
        endcase
    end

    // Outputs of the state machine.
    always_comb begin
        s_axis_tready    = (r_state == ST_IDLE);
        scr_cmd.wr_en    = (r_state == ST_EXEC) && dec_wr;
        scr_cmd.wr_addr  = dec_wr_addr;
        scr_cmd.wr_data  = dec_wr_data;
        scr_cmd.rd_en    = (r_state == ST_EXEC) && dec_rd;
        scr_cmd.rd_addr  = rd_addr;
        scr_cmd.sw_start = (r_state == ST_EXEC) && dec_sw;
        scr_cmd.sw_base  = dec_sw_base;
        scr_cmd.sw_last  = dec_sw_last;
        scr_cmd.sw_data  = blank;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_phase  <= PH_TEXT;
            r_attr   <= ATTR_RST;
            r_row    <= '0;
            r_col    <= '0;
            r_top    <= '0;
            r_param  <= '0;
            r_seen   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_attr <= i_cfg_data;
            end
            if (r_state == ST_EXEC) begin
                r_phase <= n_phase;
                r_row   <= n_row;
                r_col   <= n_col;
                r_top   <= n_top;
                r_param <= n_param;
                r_seen  <= n_seen;
            end
            if (r_state == ST_EMIT && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers: input word, read result and output word.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && s_axis_tvalid) begin
            r_action <= s_axis_tuser;
            r_byte   <= s_axis_tdata[7:0];
            r_rrow   <= s_axis_tdata[12:8];
            r_rcol   <= s_axis_tdata[19:13];
        end
        if (r_state == ST_EXEC) begin
            r_rd_ok <= r_action && rd_in_range;
            r_code  <= '0;
            r_cattr <= '0;
        end
        if (r_state == ST_RDWAIT && r_rd_ok) begin
            r_code  <= scr_stat.rd_data[7:0];
            r_cattr <= scr_stat.rd_data[15:8];
        end
        if (r_state == ST_EMIT && (!r_ovalid || m_axis_tready)) begin
            r_odata <= {4'd0, r_col, r_row, r_cattr, r_code};
        end
    end

    // Cursor and top-row pointer stay on the screen.
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row < ROW_W'(ROWS)) && (r_top < ROW_W'(ROWS)))
        else $error("cursor row or top row off screen");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col < COL_W'(COLS))
        else $error("cursor column off screen");

    // No word is taken while the memory is being filled.
    a_ready_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !scr_stat.sw_busy)
        else $error("word accepted during memory sweep");

    // A started sweep is waited for before the result is released.
    a_sweep_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scr_cmd.sw_start |=> (r_state == ST_SWEEP) && scr_stat.sw_busy)
        else $error("sweep not tracked");

endmodule
